// ----- hdl/sab_pkg.sv -----
// shared constants for the suffix array builder
package sab_pkg;

	localparam int MAX_LEN = 1024;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = IDX_W + 1;
	localparam int RANK_W  = IDX_W + 1;
	localparam int CHAR_W  = 8;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 16;
	localparam int OUT_USER_W  = 2;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_INIT = 4'd1;
	localparam logic [ST_W-1:0] ST_CLR  = 4'd2;
	localparam logic [ST_W-1:0] ST_CNT  = 4'd3;
	localparam logic [ST_W-1:0] ST_PFX  = 4'd4;
	localparam logic [ST_W-1:0] ST_SCT  = 4'd5;
	localparam logic [ST_W-1:0] ST_SEC1 = 4'd6;
	localparam logic [ST_W-1:0] ST_SEC2 = 4'd7;
	localparam logic [ST_W-1:0] ST_RNK  = 4'd8;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [RANK_W-1:0] rank_t;

endpackage

// ----- hdl/sab_ram.sv -----
// simple dual-port ram with registered read
module sab_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/suffix_array_builder.sv -----
// suffix array builder top level
//
// Append beats load a byte string (up to 1024 characters, extra ones are
// dropped and reported as truncated); the append beat with tlast set starts
// a build by prefix doubling with a counting sort in each round. Appends and
// queries are taken one per beat while the input is ready; a query's answer
// is read from the suffix array and then held in the output register until
// taken, and input stalls during a build or while an answer waits behind a
// full output. Every memory has one read and one write port and each sorted
// element walks through its reads one after another; at most ceil(log2 n)
// rounds run for n characters, ending early once all ranks are unique.
// Each answer carries the start of the k-th smallest suffix; query_error is
// set when no build has finished or k is not below the string length.
module suffix_array_builder
	import sab_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // char_value, rank_index, zero pad
	input  logic                  s_axis_tlast,  // last_char
	input  logic                  s_axis_tuser,  // cmd
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // start_index, zero pad
	output logic [OUT_USER_W-1:0] m_axis_tuser   // query_error, truncated
);

	logic [CHAR_W-1:0] char_value;
	idx_t              rank_index;

	logic [ST_W-1:0] state_q;
	logic [1:0]      sub_q;
	len_t            j_q, k_q, p_q, len_q, sum_q;
	logic            bank_q, built_q, ovf_q, has2_q;
	idx_t            elem_q, key_q, cur_q;
	rank_t           r1_q, pr1_q, pr2_q, prevnew_q;

	logic  pend_s1, perr_s1, ptrunc_s1;
	logic  out_valid_q, out_err_q, out_trunc_q;
	idx_t  out_start_q;

	logic              text_we, text_re;
	idx_t              text_waddr, text_raddr;
	logic [CHAR_W-1:0] text_wdata, text_rdata;
	logic              sa_we, sa_re;
	idx_t              sa_waddr, sa_raddr, sa_wdata, sa_rdata;
	logic              tmp_we, tmp_re;
	idx_t              tmp_waddr, tmp_raddr, tmp_wdata, tmp_rdata;
	logic              cnt_we, cnt_re;
	idx_t              cnt_waddr, cnt_raddr;
	len_t              cnt_wdata, cnt_rdata;
	logic              rank_we, rank_re;
	logic [IDX_W:0]    rank_waddr, rank_raddr;
	rank_t             rank_wdata, rank_rdata;

	logic    in_acc, app_acc, qry_acc, load;
	logic    last_el, last_tab;
	logic    diff;
	rank_t   r2, newr;
	logic [LEN_W:0] cur_plus_k;
	len_t    k_next;

	assign char_value = s_axis_tdata[CHAR_W-1:0];
	assign rank_index = s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W];

	assign load          = pend_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE) && (!pend_s1 || !out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign app_acc       = in_acc && (s_axis_tuser == CMD_APPEND);
	assign qry_acc       = in_acc && (s_axis_tuser == CMD_QUERY);

	assign last_el  = (j_q == len_q - LEN_W'(1));
	assign last_tab = (j_q == LEN_W'(MAX_LEN - 1));

	assign cur_plus_k = (LEN_W+1)'(cur_q) + (LEN_W+1)'(k_q);
	assign r2         = has2_q ? rank_rdata : '0;
	assign diff       = (r1_q != pr1_q) || (r2 != pr2_q);
	assign newr       = (j_q == '0) ? RANK_W'(1) : prevnew_q + RANK_W'(diff);
	assign k_next     = k_q << 1;

	// memory port steering
	always_comb begin
		text_we = 1'b0; text_waddr = '0; text_wdata = char_value;
		text_re = 1'b0; text_raddr = j_q[IDX_W-1:0];
		sa_we = 1'b0; sa_waddr = '0; sa_wdata = elem_q;
		sa_re = 1'b0; sa_raddr = j_q[IDX_W-1:0];
		tmp_we = 1'b0; tmp_waddr = j_q[IDX_W-1:0]; tmp_wdata = j_q[IDX_W-1:0];
		tmp_re = 1'b0; tmp_raddr = j_q[IDX_W-1:0];
		cnt_we = 1'b0; cnt_waddr = j_q[IDX_W-1:0]; cnt_wdata = '0;
		cnt_re = 1'b0; cnt_raddr = j_q[IDX_W-1:0];
		rank_we = 1'b0; rank_waddr = '0; rank_wdata = '0;
		rank_re = 1'b0; rank_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				text_we    = app_acc && (built_q || len_q < LEN_W'(MAX_LEN));
				text_waddr = built_q ? '0 : len_q[IDX_W-1:0];
				sa_re      = qry_acc;
				sa_raddr   = rank_index;
			end
			ST_INIT: begin
				text_re    = (sub_q == 2'd0);
				rank_we    = (sub_q == 2'd1);
				rank_waddr = {1'b0, j_q[IDX_W-1:0]};
				rank_wdata = RANK_W'(text_rdata) + RANK_W'(1);
				tmp_we     = (sub_q == 2'd1);
			end
			ST_CLR: begin
				cnt_we = 1'b1;
			end
			ST_CNT, ST_SCT: begin
				tmp_re     = (sub_q == 2'd0);
				rank_re    = (sub_q == 2'd1);
				rank_raddr = {bank_q, tmp_rdata};
				cnt_re     = (sub_q == 2'd2);
				cnt_raddr  = IDX_W'(rank_rdata - RANK_W'(1));
				cnt_we     = (sub_q == 2'd3);
				cnt_waddr  = key_q;
				cnt_wdata  = cnt_rdata + LEN_W'(1);
				sa_we      = (state_q == ST_SCT) && (sub_q == 2'd3);
				sa_waddr   = cnt_rdata[IDX_W-1:0];
			end
			ST_PFX: begin
				cnt_re    = (sub_q == 2'd0);
				cnt_we    = (sub_q == 2'd1);
				cnt_wdata = sum_q;
			end
			ST_SEC1: begin
				tmp_we    = 1'b1;
				tmp_wdata = IDX_W'(len_q - k_q + j_q);
			end
			ST_SEC2: begin
				sa_re     = (sub_q == 2'd0);
				tmp_we    = (sub_q == 2'd1) && ({1'b0, sa_rdata} >= k_q);
				tmp_waddr = p_q[IDX_W-1:0];
				tmp_wdata = IDX_W'(LEN_W'(sa_rdata) - k_q);
			end
			ST_RNK: begin
				sa_re = (sub_q == 2'd0);
				if (sub_q == 2'd1) begin
					rank_re    = 1'b1;
					rank_raddr = {bank_q, sa_rdata};
				end
				if (sub_q == 2'd2) begin
					rank_re    = (cur_plus_k < (LEN_W+1)'(len_q));
					rank_raddr = {bank_q, cur_plus_k[IDX_W-1:0]};
				end
				rank_we    = (sub_q == 2'd3);
				rank_waddr = {~bank_q, cur_q};
				rank_wdata = newr;
			end
			default: begin
			end
		endcase
	end

	// build sequencer and string bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q   <= '0;
			j_q     <= '0;
			k_q     <= '0;
			p_q     <= '0;
			sum_q   <= '0;
			len_q   <= '0;
			bank_q  <= 1'b0;
			built_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (app_acc) begin
						if (built_q) begin
							len_q   <= LEN_W'(1);
							ovf_q   <= 1'b0;
							built_q <= 1'b0;
						end else if (len_q < LEN_W'(MAX_LEN)) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							built_q <= 1'b1;
							state_q <= ST_INIT;
							j_q     <= '0;
							sub_q   <= '0;
							k_q     <= '0;
							bank_q  <= 1'b0;
						end
					end
				end
				ST_INIT: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						j_q   <= last_el ? '0 : j_q + LEN_W'(1);
						if (last_el) state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					j_q <= last_tab ? '0 : j_q + LEN_W'(1);
					if (last_tab) begin
						state_q <= ST_CNT;
						sub_q   <= '0;
					end
				end
				ST_CNT, ST_SCT: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1) elem_q <= tmp_rdata;
					if (sub_q == 2'd2) key_q <= IDX_W'(rank_rdata - RANK_W'(1));
					if (sub_q == 2'd3) begin
						j_q <= last_el ? '0 : j_q + LEN_W'(1);
						if (last_el) begin
							if (state_q == ST_CNT) begin
								state_q <= ST_PFX;
								sum_q   <= '0;
							end else if (k_q == '0) begin
								k_q     <= LEN_W'(1);
								state_q <= (len_q > LEN_W'(1)) ? ST_SEC1 : ST_IDLE;
							end else begin
								state_q <= ST_RNK;
							end
						end
					end
				end
				ST_PFX: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						sum_q <= sum_q + cnt_rdata;
						j_q   <= last_tab ? '0 : j_q + LEN_W'(1);
						if (last_tab) state_q <= ST_SCT;
					end
				end
				ST_SEC1: begin
					// suffixes with no second half lead the second-key order
					if (j_q == k_q - LEN_W'(1)) begin
						j_q     <= '0;
						p_q     <= k_q;
						sub_q   <= '0;
						state_q <= ST_SEC2;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				ST_SEC2: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if ({1'b0, sa_rdata} >= k_q) p_q <= p_q + LEN_W'(1);
						j_q <= last_el ? '0 : j_q + LEN_W'(1);
						if (last_el) state_q <= ST_CLR;
					end
				end
				ST_RNK: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1) cur_q <= sa_rdata;
					if (sub_q == 2'd2) begin
						r1_q   <= rank_rdata;
						has2_q <= (cur_plus_k < (LEN_W+1)'(len_q));
					end
					if (sub_q == 2'd3) begin
						pr1_q     <= r1_q;
						pr2_q     <= r2;
						prevnew_q <= newr;
						j_q       <= last_el ? '0 : j_q + LEN_W'(1);
						if (last_el) begin
							bank_q <= ~bank_q;
							k_q    <= k_next;
							if (LEN_W'(newr) == len_q || k_next >= len_q) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_SEC1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query answer path: read beat, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (qry_acc) begin
				pend_s1 <= 1'b1;
			end else if (load) begin
				pend_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qry_acc) begin
			perr_s1   <= !built_q || (LEN_W'(rank_index) >= len_q);
			ptrunc_s1 <= ovf_q;
		end
		if (load) begin
			out_start_q <= perr_s1 ? '0 : sa_rdata;
			out_err_q   <= perr_s1;
			out_trunc_q <= ptrunc_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_start_q);
	assign m_axis_tuser  = {out_trunc_q, out_err_q};

	sab_ram #(.DATA_W(CHAR_W), .ADDR_W(IDX_W)) u_text (
		.clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
		.re(text_re), .raddr(text_raddr), .rdata(text_rdata)
	);

	sab_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_sa (
		.clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
		.re(sa_re), .raddr(sa_raddr), .rdata(sa_rdata)
	);

	sab_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_tmp (
		.clk(clk), .we(tmp_we), .waddr(tmp_waddr), .wdata(tmp_wdata),
		.re(tmp_re), .raddr(tmp_raddr), .rdata(tmp_rdata)
	);

	sab_ram #(.DATA_W(LEN_W), .ADDR_W(IDX_W)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	// two rank banks, current and next
	sab_ram #(.DATA_W(RANK_W), .ADDR_W(IDX_W + 1)) u_rank (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata)
	);

endmodule

// ----- test/suffix_array_builder_tb.sv -----
// testbench for the suffix array builder: directed table, then random strings and queries
`timescale 1ns / 100ps

module suffix_array_builder_tb;
	import sab_pkg::*;

	localparam int LIMIT = 20_000_000;

	typedef struct {
		idx_t idx;
		logic err;
		logic trunc;
	} answer_t;

	typedef struct {
		logic       cmd;
		logic [7:0] ch;
		logic       last;
		idx_t       k;
		logic       typed;
		answer_t    ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// predictor state
	logic [7:0] text_buf[MAX_LEN];
	int         suffix_pos[MAX_LEN];
	int         text_len = 0;
	logic       is_built = 1'b0;
	logic       is_cut = 1'b0;

	answer_t answer_q[$];
	logic    row_typed = 1'b0;
	answer_t row_ans;
	int      send_idle = 0;
	int      recv_stall = 0;
	int      mismatches = 0;
	int      answers_seen = 0;
	int      error_answers = 0;
	int      builds_done = 0;
	longint  cycles = 0;

	suffix_array_builder i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycles,
				answer_q.size());
			$display("suffix_array_builder regression: fail");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	// true when the suffix at a sorts before the suffix at b
	function automatic logic suffix_below(int a, int b);
		int i;
		for (i = 0; a + i < text_len && b + i < text_len; i++)
			if (text_buf[a + i] != text_buf[b + i])
				return text_buf[a + i] < text_buf[b + i];
		return (a + i) == text_len;
	endfunction

	task automatic sort_suffixes();
		int j;
		int v;
		for (int i = 0; i < text_len; i++) begin
			v = i;
			j = i - 1;
			while (j >= 0 && suffix_below(v, suffix_pos[j])) begin
				suffix_pos[j + 1] = suffix_pos[j];
				j--;
			end
			suffix_pos[j + 1] = v;
		end
		builds_done++;
	endtask

	function automatic answer_t lookup_answer(idx_t k);
		answer_t a;
		a.err = !is_built || k >= text_len;
		a.idx = a.err ? '0 : idx_t'(suffix_pos[k]);
		a.trunc = is_cut;
		return a;
	endfunction

	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (s_axis_tuser == CMD_APPEND) begin
				if (is_built) begin
					text_len = 0;
					is_cut = 1'b0;
					is_built = 1'b0;
				end
				if (text_len < MAX_LEN) begin
					text_buf[text_len] = s_axis_tdata[7:0];
					text_len++;
				end else
					is_cut = 1'b1;
				if (s_axis_tlast) begin
					sort_suffixes();
					is_built = 1'b1;
				end
			end else
				answer_q.push_back(row_typed ? row_ans : lookup_answer(s_axis_tdata[17:8]));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idx = m_axis_tdata[IDX_W-1:0];
			got.err = m_axis_tuser[0];
			got.trunc = m_axis_tuser[1];
			answers_seen++;
			if (got.err)
				error_answers++;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer idx=%0d err=%b trunc=%b", got.idx, got.err,
						got.trunc);
			end else begin
				want = answer_q.pop_front();
				if (got.idx !== want.idx || got.err !== want.err || got.trunc !== want.trunc ||
						m_axis_tdata[OUT_DATA_W-1:IDX_W] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("answer mismatch: expected idx=%0d err=%b trunc=%b, got %0d %b %b",
							want.idx, want.err, want.trunc, got.idx, got.err, got.trunc);
				end
			end
		end
	end

	task automatic send_beat(row_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.cmd;
		s_axis_tlast <= r.last;
		s_axis_tdata <= {6'b0, r.k, r.ch};
		row_typed <= r.typed;
		row_ans <= r.ans;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic row_t append_row(logic [7:0] ch, logic last);
		row_t r;
		r = '{CMD_APPEND, ch, last, idx_t'($urandom), 1'b0, '{'0, 1'b0, 1'b0}};
		return r;
	endfunction

	function automatic row_t query_row(idx_t k);
		row_t r;
		r = '{CMD_QUERY, 8'($urandom), 1'b0, k, 1'b0, '{'0, 1'b0, 1'b0}};
		return r;
	endfunction

	function automatic row_t typed_query(idx_t k, idx_t idx, logic err, logic trunc);
		row_t r;
		r = '{CMD_QUERY, 8'h00, 1'b0, k, 1'b1, '{idx, err, trunc}};
		return r;
	endfunction

	row_t directed[] = '{
		typed_query(10'd0, 10'd0, 1'b1, 1'b0),     // nothing built yet
		typed_query(10'd1023, 10'd0, 1'b1, 1'b0),
		append_row(8'hff, 1'b1),                   // one-character string
		typed_query(10'd0, 10'd0, 1'b0, 1'b0),
		typed_query(10'd1, 10'd0, 1'b1, 1'b0),
		typed_query(10'd1023, 10'd0, 1'b1, 1'b0),
		append_row(8'h00, 1'b0),                   // all-zero string
		typed_query(10'd0, 10'd0, 1'b1, 1'b0),     // still loading
		append_row(8'h00, 1'b0),
		append_row(8'h00, 1'b1),
		typed_query(10'd0, 10'd2, 1'b0, 1'b0),
		typed_query(10'd2, 10'd0, 1'b0, 1'b0),
		typed_query(10'd3, 10'd0, 1'b1, 1'b0),
		append_row(8'hff, 1'b0),                   // mixed extremes
		append_row(8'h00, 1'b0),
		append_row(8'hff, 1'b0),
		append_row(8'h00, 1'b0),
		append_row(8'h80, 1'b1),
		query_row(10'd0),
		query_row(10'd1),
		query_row(10'd2),
		query_row(10'd3),
		query_row(10'd4),
		query_row(10'd5)
	};

	initial begin
		int items;
		int len;
		int flavor;
		int nq;
		int strings;
		logic [7:0] c;
		items = 0;
		strings = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_beat(directed[i]);

		while (items < 1800) begin
			case ((items / 150) % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 68; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 68; end
				default: begin send_idle = 11; recv_stall = 11; end
			endcase
			flavor = $urandom_range(9);
			len = (strings == 3) ? MAX_LEN + 6 : $urandom_range(1, 64);
			if (flavor == 0 && strings != 3)
				len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				case (flavor % 4)
					0: c = 8'($urandom);
					1: c = 8'($urandom_range(1));          // tiny alphabet, many repeats
					2: c = 8'h61;                          // one repeated character
					default: c = $urandom_range(1) ? 8'hff : 8'h00;
				endcase
				// noise: a query while the string is still loading
				if (i > 0 && $urandom_range(19) == 0) begin
					send_beat(query_row(idx_t'($urandom)));
					items++;
				end
				send_beat(append_row(c, i == len - 1));
				items++;
			end
			strings++;
			nq = $urandom_range(5, 25);
			for (int q = 0; q < nq; q++) begin
				if (len > MAX_LEN && q == 0)
					send_beat(query_row(10'd1023));
				else if ($urandom_range(9) == 0)
					send_beat(query_row(idx_t'($urandom)));
				else
					send_beat(query_row(idx_t'($urandom_range(len > MAX_LEN ? MAX_LEN - 1 : len))));
				items++;
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		recv_stall = 0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (answer_q.size() != 0)
			mismatches++;

		$display("covered %0d random items over %0d strings (%0d builds, one past capacity)",
			items, strings, builds_done);
		$display("answers checked: %0d, with query errors: %0d, mismatches: %0d",
			answers_seen, error_answers, mismatches);
		if (mismatches == 0)
			$display("suffix_array_builder regression: pass");
		else
			$display("suffix_array_builder regression: fail");
		$finish;
	end

endmodule

// ----- suffix_array_builder.f -----
hdl/sab_pkg.sv
hdl/sab_ram.sv
hdl/suffix_array_builder.sv
test/suffix_array_builder_tb.sv
